/* sv/vmpg_pkg.sv */
// Shared types, constants and helpers for the vector-matrix product / gradient unit.
package vmpg_pkg;

  localparam int MAX_IN  = 256;
  localparam int IDX_W   = $clog2(MAX_IN);
  localparam int LEN_W   = 9;
  localparam int CNT_W   = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
  localparam int OPD_W   = 16;
  localparam int VAL_W   = 40;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_BWD  = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_DOT   = 2'd0,
    KIND_MGRAD = 2'd1,
    KIND_IGRAD = 2'd2
  } kind_t;

  // One classified request as it travels from the front end to the datapath.
  typedef struct packed {
    action_t                  action;
    logic signed [OPD_W-1:0]  a;
    logic signed [OPD_W-1:0]  b;
    logic signed [VAL_W-1:0]  g;
    logic [IDX_W-1:0]         idx;
    logic                     row_end;
  } vmpg_item_t;

  // Clamp a 41-bit sum into the signed 40-bit range.
  function automatic logic signed [VAL_W-1:0] sat40(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[VAL_W] != v[VAL_W-1]) begin
      r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/vmpg_front.sv */
// Front end: takes requests, walks the column counter and classifies each item.
module vmpg_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [vmpg_pkg::LEN_W-1:0]        in_length,
  input  logic                              cfg_write,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic signed [vmpg_pkg::OPD_W-1:0] operand_a,
  input  logic signed [vmpg_pkg::OPD_W-1:0] operand_b,
  input  logic signed [vmpg_pkg::VAL_W-1:0] gradient_in,
  input  logic                              q_full,
  output logic                              push,
  output vmpg_pkg::vmpg_item_t              item
);

  logic [vmpg_pkg::IDX_W-1:0] column;
  logic [vmpg_pkg::IDX_W-1:0] column_next;
  logic [vmpg_pkg::CNT_W-1:0] len_ext;
  logic [vmpg_pkg::CNT_W-1:0] eff_len;
  logic [vmpg_pkg::IDX_W-1:0] idx;
  logic                       row_end;

  // zero acts as one, anything past the store depth as the full depth
  always_comb begin
    len_ext = vmpg_pkg::CNT_W'(in_length);
    if (len_ext == '0) begin
      eff_len = vmpg_pkg::CNT_W'(1);
    end else if (len_ext > vmpg_pkg::CNT_W'(vmpg_pkg::MAX_IN)) begin
      eff_len = vmpg_pkg::CNT_W'(vmpg_pkg::MAX_IN);
    end else begin
      eff_len = len_ext;
    end
  end

  always_comb begin
    idx = (vmpg_pkg::CNT_W'(column) >= eff_len) ? '0 : column;
    row_end = (vmpg_pkg::CNT_W'(idx) + vmpg_pkg::CNT_W'(1)) >= eff_len;
    column_next = row_end ? '0 : idx + vmpg_pkg::IDX_W'(1);
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.action  = vmpg_pkg::action_t'(action);
    item.a       = operand_a;
    item.b       = operand_b;
    item.g       = gradient_in;
    item.idx     = idx;
    item.row_end = row_end;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column <= '0;
    end else if (push) begin
      column <= column_next;
    end
  end

endmodule

/* sv/vmpg_queue.sv */
// Short request queue between the front end and the datapath.
module vmpg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vmpg_pkg::vmpg_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output vmpg_pkg::vmpg_item_t q_item
);

  vmpg_pkg::vmpg_item_t         entries [vmpg_pkg::Q_DEPTH];
  logic [vmpg_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [vmpg_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [vmpg_pkg::Q_CNT_W-1:0] count;

  assign full    = count == vmpg_pkg::Q_CNT_W'(vmpg_pkg::Q_DEPTH);
  assign q_valid = count != '0;
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == vmpg_pkg::Q_PTR_W'(vmpg_pkg::Q_DEPTH - 1)) ?
                  '0 : wr_ptr + vmpg_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == vmpg_pkg::Q_PTR_W'(vmpg_pkg::Q_DEPTH - 1)) ?
                  '0 : rd_ptr + vmpg_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + vmpg_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - vmpg_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

/* sv/vmpg_back.sv */
// Datapath: vector stores, multipliers, accumulator and the result register.
module vmpg_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              acc_clear,
  input  logic                              q_valid,
  input  vmpg_pkg::vmpg_item_t              q_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vmpg_pkg::kind_t                   out_kind,
  output logic signed [vmpg_pkg::VAL_W-1:0] out_value,
  output logic                              out_last
);

  localparam int OW = vmpg_pkg::OPD_W;
  localparam int VW = vmpg_pkg::VAL_W;
  localparam int PW = vmpg_pkg::PROD_W;

  logic signed [OW-1:0] in_mem   [vmpg_pkg::MAX_IN];
  logic signed [VW-1:0] grad_mem [vmpg_pkg::MAX_IN];

  logic en;

  // stage 1: store read data
  logic                 s1_valid;
  vmpg_pkg::vmpg_item_t s1_item;
  logic signed [OW-1:0] s1_x;
  logic signed [VW-1:0] s1_grd;
  logic                 s1_byp_hit;
  logic signed [VW-1:0] s1_byp_val;
  logic signed [VW-1:0] s1_gsel;
  logic signed [OW-1:0] s1_mul_op;
  logic signed [PW-1:0] s1_m1;
  logic signed [PW-1:0] s1_m2;

  // stage 2: products
  logic                 s2_valid;
  vmpg_pkg::vmpg_item_t s2_item;
  logic signed [PW-1:0] s2_m1;
  logic signed [PW-1:0] s2_m2;
  logic signed [VW-1:0] s2_gsel;
  logic signed [VW-1:0] s2_base;
  logic signed [VW-1:0] s2_sum;
  logic signed [VW-1:0] s2_gnew;
  logic                 s2_wr;
  logic                 s2_res_valid;
  vmpg_pkg::kind_t      s2_kind;
  logic signed [VW-1:0] s2_value;
  logic                 s2_last;

  logic signed [VW-1:0] acc;

  assign en  = !out_valid || !out_stall;
  assign pop = q_valid && en;

  // Stores: input element written on issue; gradient written back from stage 2.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_item.action == vmpg_pkg::ACT_LOAD) begin
        in_mem[q_item.idx] <= q_item.a;
      end
      s1_x   <= in_mem[q_item.idx];
      s1_grd <= grad_mem[q_item.idx];
    end
    if (en && s2_wr) begin
      grad_mem[s2_item.idx] <= s2_gnew;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item    <= q_item;
      // gradient store is read-first, so catch a write-back to the same entry
      s1_byp_hit <= s2_wr && (s2_item.idx == q_item.idx);
      s1_byp_val <= s2_gnew;
    end
    if (en) begin
      s2_item <= s1_item;
      s2_m1   <= s1_m1;
      s2_m2   <= s1_m2;
      s2_gsel <= s1_gsel;
    end
  end

  always_comb begin
    if (s2_wr && (s2_item.idx == s1_item.idx)) begin
      s1_gsel = s2_gnew;
    end else if (s1_byp_hit) begin
      s1_gsel = s1_byp_val;
    end else begin
      s1_gsel = s1_grd;
    end
    s1_mul_op = (s1_item.action == vmpg_pkg::ACT_FWD) ? s1_item.a : s1_item.b;
    s1_m1     = s1_mul_op * s1_x;
    s1_m2     = s1_item.b * s1_item.a;
  end

  always_comb begin
    s2_base = (s2_item.action == vmpg_pkg::ACT_FWD) ? acc : s2_item.g;
    s2_sum  = vmpg_pkg::sat40({s2_base[VW-1], s2_base} + {{(VW+1-PW){s2_m1[PW-1]}}, s2_m1});
    if (s2_item.action == vmpg_pkg::ACT_LOAD) begin
      s2_gnew = s2_item.g;
    end else begin
      s2_gnew = vmpg_pkg::sat40({s2_gsel[VW-1], s2_gsel} + {{(VW+1-PW){s2_m2[PW-1]}}, s2_m2});
    end
    s2_wr = s2_valid &&
            (s2_item.action == vmpg_pkg::ACT_LOAD || s2_item.action == vmpg_pkg::ACT_BWD);
  end

  always_comb begin
    s2_res_valid = 1'b0;
    s2_kind      = vmpg_pkg::KIND_DOT;
    s2_value     = s2_sum;
    s2_last      = s2_item.row_end;
    case (s2_item.action)
      vmpg_pkg::ACT_LOAD: begin
        s2_res_valid = 1'b0;
      end
      vmpg_pkg::ACT_FWD: begin
        s2_res_valid = s2_valid && s2_item.row_end;
        s2_last      = 1'b1;
      end
      vmpg_pkg::ACT_BWD: begin
        s2_res_valid = s2_valid;
        s2_kind      = vmpg_pkg::KIND_MGRAD;
      end
      vmpg_pkg::ACT_READ: begin
        s2_res_valid = s2_valid;
        s2_kind      = vmpg_pkg::KIND_IGRAD;
        s2_value     = s2_gsel;
      end
      default: begin
        s2_res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind  <= s2_kind;
      out_value <= s2_value;
      out_last  <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      acc <= '0;
    end else if (en && s2_valid && s2_item.action == vmpg_pkg::ACT_FWD) begin
      acc <= s2_item.row_end ? '0 : s2_sum;
    end
  end

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    acc_clear |=> acc == '0)
    else $error("accumulator not cleared by length write");

  a_row_clears_acc: assert property (@(posedge clk) disable iff (rst)
    (en && s2_valid && s2_item.action == vmpg_pkg::ACT_FWD && s2_item.row_end)
      |=> acc == '0)
    else $error("accumulator kept its value past the end of a row");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(s1_valid) && $stable(s2_valid) && $stable(acc))
    else $error("pipeline moved while the result was stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_item.action == vmpg_pkg::ACT_LOAD) |-> !s2_res_valid)
    else $error("load produced a result");

endmodule

/* sv/vector_matrix_product_grad_unit.sv */
// Top level of the dense-layer vector-matrix product unit with backward pass.
// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle unless
//   in_stall is high: action, operand_a, operand_b, gradient_in. Requests sit in
//   a four-entry queue; in_stall rises only when that queue is full.
//   Output channel (out_valid / out_stall) gives kind, output_value and last.
//   A load gives no result, a forward gives one only at the end of a row.
//   Path: a request passes the queue, store read, multiply and add/saturate into
//   the output register.
//   Throughput: one request per cycle unless stalled, set by the single issue port
//   of the datapath; a column counter shared by all actions selects the store
//   entry; back-to-back gradient updates to one entry are forwarded, not stalled.
//   Stall: while out_stall holds a pending result, the datapath freezes, the
//   queue fills, and then in_stall is raised. Nothing is dropped.
//   Configuration: in_length is written over cfg_valid / cfg_ready (always
//   ready); a write clears the column counter and the accumulator and is to be
//   made only while no request is in flight.
//   Reset (rst, synchronous): the length register returns to 256, column and
//   accumulator to zero, queue and pipeline emptied. The vector stores are not
//   cleared and must be loaded before use.
module vector_matrix_product_grad_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vmpg_pkg::LEN_W-1:0]        in_length,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic signed [vmpg_pkg::OPD_W-1:0] operand_a,
  input  logic signed [vmpg_pkg::OPD_W-1:0] operand_b,
  input  logic signed [vmpg_pkg::VAL_W-1:0] gradient_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic signed [vmpg_pkg::VAL_W-1:0] output_value,
  output logic                              last
);

  logic [vmpg_pkg::LEN_W-1:0] length;
  logic                       cfg_write;
  logic                       push;
  logic                       q_full;
  logic                       q_valid;
  logic                       pop;
  vmpg_pkg::vmpg_item_t       push_item;
  vmpg_pkg::vmpg_item_t       q_item;
  vmpg_pkg::kind_t            out_kind;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign kind      = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= vmpg_pkg::LEN_RESET;
    end else if (cfg_write) begin
      length <= in_length;
    end
  end

  vmpg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_length   (length),
    .cfg_write   (cfg_write),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .gradient_in (gradient_in),
    .q_full      (q_full),
    .push        (push),
    .item        (push_item)
  );

  vmpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  vmpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .acc_clear (cfg_write),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (output_value),
    .out_last  (last)
  );

endmodule

/* bench/vector_matrix_product_grad_unit_tb.sv */
// Self-checking bench for the vector-matrix product / gradient unit: directed and random requests
module vector_matrix_product_grad_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned ITEM_TARGET   = 2000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam longint      VAL_HI        = 64'sh7F_FFFF_FFFF;
  localparam longint      VAL_LO        = -64'sh80_0000_0000;
  localparam logic signed [vmpg_pkg::OPD_W-1:0] OPD_MIN = 16'sh8000;
  localparam logic signed [vmpg_pkg::OPD_W-1:0] OPD_MAX = 16'sh7FFF;
  localparam logic signed [vmpg_pkg::VAL_W-1:0] WIDE_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [vmpg_pkg::VAL_W-1:0] WIDE_MIN = 40'sh80_0000_0000;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_LIGHT,
    PACE_HEAVY
  } pace_t;

  typedef struct {
    vmpg_pkg::action_t                 act;
    logic signed [vmpg_pkg::OPD_W-1:0] a;
    logic signed [vmpg_pkg::OPD_W-1:0] b;
    logic signed [vmpg_pkg::VAL_W-1:0] g;
  } layer_req_t;

  typedef struct {
    vmpg_pkg::kind_t                   kind;
    logic signed [vmpg_pkg::VAL_W-1:0] value;
    logic                              last;
  } layer_res_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [vmpg_pkg::LEN_W-1:0]        in_length = vmpg_pkg::LEN_RESET;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        action = vmpg_pkg::ACT_LOAD;
  logic signed [vmpg_pkg::OPD_W-1:0] operand_a = '0;
  logic signed [vmpg_pkg::OPD_W-1:0] operand_b = '0;
  logic signed [vmpg_pkg::VAL_W-1:0] gradient_in = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [1:0]                        kind;
  logic signed [vmpg_pkg::VAL_W-1:0] output_value;
  logic                              last;

  // predictor state
  logic signed [vmpg_pkg::OPD_W-1:0] vec_mirror [vmpg_pkg::MAX_IN];
  longint                            grad_mirror [vmpg_pkg::MAX_IN];
  longint                            acc_mirror = 0;
  int unsigned                       col_mirror = 0;
  logic [vmpg_pkg::LEN_W-1:0]        len_mirror = vmpg_pkg::LEN_RESET;
  layer_res_t                        awaited_results [$];

  // request generator state: tracks the column so no unloaded entry is ever read
  layer_req_t              pending_reqs [$];
  int unsigned             gen_len = vmpg_pkg::MAX_IN;
  int unsigned             gen_col = 0;
  bit                      gen_loaded [vmpg_pkg::MAX_IN];
  int unsigned             queued_items = 0;

  pace_t                   tx_pace = PACE_FULL;
  pace_t                   rx_pace = PACE_FULL;
  layer_req_t              cur_req;
  bit                      tx_busy;
  int unsigned             tx_gap = 0;
  int unsigned             rx_wait = 0;
  int unsigned             hold_left = 0;
  bit                      hold_req = 1'b0;
  layer_res_t              rx_want;
  int unsigned             errors = 0;
  int unsigned             cycle_count = 0;

  vector_matrix_product_grad_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_length    (in_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .gradient_in  (gradient_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .output_value (output_value),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vector_matrix_product_grad_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned active_len(input logic [vmpg_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > vmpg_pkg::MAX_IN) return vmpg_pkg::MAX_IN;
    return v;
  endfunction

  function automatic longint clamp40(input longint v);
    if (v > VAL_HI) return VAL_HI;
    if (v < VAL_LO) return VAL_LO;
    return v;
  endfunction

  function automatic int unsigned draw_wait(input pace_t p);
    case (p)
      PACE_FULL:  return 0;
      PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      default:    return $urandom_range(0, 13);
    endcase
  endfunction

  // Expected outcome of one accepted request; updates the mirrored stores.
  function automatic void layer_step(input layer_req_t r);
    int unsigned len;
    int unsigned idx;
    bit          row_end;
    longint      x;
    longint      a;
    longint      b;
    longint      g;
    layer_res_t  res;
    len = active_len(len_mirror);
    idx = col_mirror;
    if (idx >= len) idx = 0;
    row_end = (idx + 1 >= len);
    x = vec_mirror[idx];
    a = r.a;
    b = r.b;
    g = r.g;
    res.last = row_end;
    case (r.act)
      vmpg_pkg::ACT_LOAD: begin
        vec_mirror[idx] = r.a;
        grad_mirror[idx] = g;
      end
      vmpg_pkg::ACT_FWD: begin
        acc_mirror = clamp40(acc_mirror + a * x);
        if (row_end) begin
          res.kind = vmpg_pkg::KIND_DOT;
          res.value = acc_mirror[vmpg_pkg::VAL_W-1:0];
          awaited_results.push_back(res);
          acc_mirror = 0;
        end
      end
      vmpg_pkg::ACT_BWD: begin
        grad_mirror[idx] = clamp40(grad_mirror[idx] + b * a);
        res.kind = vmpg_pkg::KIND_MGRAD;
        res.value = vmpg_pkg::VAL_W'(clamp40(g + b * x));
        awaited_results.push_back(res);
      end
      default: begin
        res.kind = vmpg_pkg::KIND_IGRAD;
        res.value = grad_mirror[idx][vmpg_pkg::VAL_W-1:0];
        awaited_results.push_back(res);
      end
    endcase
    col_mirror = row_end ? 0 : idx + 1;
  endfunction

  function automatic logic signed [vmpg_pkg::OPD_W-1:0] rand_opd();
    case ($urandom_range(0, 7))
      0:       return OPD_MIN;
      1:       return OPD_MAX;
      2:       return '0;
      default: return vmpg_pkg::OPD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [vmpg_pkg::VAL_W-1:0] rand_wide();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return WIDE_MAX;
      1:       return WIDE_MIN;
      2:       return '0;
      3:       return vmpg_pkg::VAL_W'($signed(r[23:0]));
      default: return r[vmpg_pkg::VAL_W-1:0];
    endcase
  endfunction

  // Any action on an entry not yet loaded is turned into a load.
  function automatic void push_req(input vmpg_pkg::action_t act,
                                   input logic signed [vmpg_pkg::OPD_W-1:0] a,
                                   input logic signed [vmpg_pkg::OPD_W-1:0] b,
                                   input logic signed [vmpg_pkg::VAL_W-1:0] g);
    layer_req_t  r;
    int unsigned idx;
    idx = (gen_col >= gen_len) ? 0 : gen_col;
    r.act = (act != vmpg_pkg::ACT_LOAD && !gen_loaded[idx]) ? vmpg_pkg::ACT_LOAD : act;
    r.a = a;
    r.b = b;
    r.g = g;
    if (r.act == vmpg_pkg::ACT_LOAD) gen_loaded[idx] = 1'b1;
    gen_col = (idx + 1 >= gen_len) ? 0 : idx + 1;
    pending_reqs.push_back(r);
    queued_items++;
  endfunction

  // Load the vector, stream rows forward and backward, read the gradients back.
  function automatic void queue_layer_pass(input int unsigned rows);
    int unsigned n;
    n = gen_len;
    repeat (n) push_req(vmpg_pkg::ACT_LOAD, rand_opd(), rand_opd(), rand_wide());
    repeat (rows * n) push_req(vmpg_pkg::ACT_FWD, rand_opd(), rand_opd(), rand_wide());
    repeat (rows * n) push_req(vmpg_pkg::ACT_BWD, rand_opd(), rand_opd(), rand_wide());
    repeat (n) push_req(vmpg_pkg::ACT_READ, rand_opd(), rand_opd(), rand_wide());
  endfunction

  function automatic void queue_noise(input int unsigned count);
    repeat (count) push_req(vmpg_pkg::action_t'($urandom_range(0, 3)), rand_opd(),
                            rand_opd(), rand_wide());
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_busy = in_valid;
      if (in_valid && !in_stall) begin
        layer_step(cur_req);
        tx_busy = 1'b0;
        tx_gap = draw_wait(tx_pace);
      end else if (!in_valid && tx_gap != 0) begin
        tx_gap--;
      end
      if (!tx_busy && tx_gap == 0 && pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        action <= cur_req.act;
        operand_a <= cur_req.a;
        operand_b <= cur_req.b;
        gradient_in <= cur_req.g;
        tx_busy = 1'b1;
      end
      in_valid <= tx_busy;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d value %0d last %0d",
                   $time, kind, output_value, last);
          errors++;
        end else begin
          rx_want = awaited_results.pop_front();
          if (kind !== rx_want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, rx_want.kind, kind);
            errors++;
          end
          if (output_value !== rx_want.value) begin
            $display("%0t: output_value mismatch, expected %0d, got %0d", $time,
                     rx_want.value, output_value);
            errors++;
          end
          if (last !== rx_want.last) begin
            $display("%0t: last mismatch, expected %0d, got %0d", $time, rx_want.last, last);
            errors++;
          end
        end
        rx_wait = draw_wait(rx_pace);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  task automatic write_length(input logic [vmpg_pkg::LEN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    in_length <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    len_mirror = v;
    col_mirror = 0;
    acc_mirror = 0;
    gen_len = active_len(v);
    gen_col = 0;
  endtask

  // Wait for every request to go in and every result to come out; a forward gives no
  // result before its row end, so a settle wait afterwards lets the pipeline empty.
  task automatic drain_block();
    int unsigned waited;
    waited = 0;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      errors++;
      awaited_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned r;
    int unsigned i;
    logic [vmpg_pkg::LEN_W-1:0] new_len;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two-element vector with extreme operands and saturating gradients
    write_length(9'd2);
    push_req(vmpg_pkg::ACT_LOAD, OPD_MIN, '0, WIDE_MAX);
    push_req(vmpg_pkg::ACT_LOAD, OPD_MAX, '0, WIDE_MIN);
    push_req(vmpg_pkg::ACT_FWD, OPD_MIN, '0, '0);
    push_req(vmpg_pkg::ACT_FWD, OPD_MAX, '0, '0);
    push_req(vmpg_pkg::ACT_BWD, OPD_MIN, OPD_MIN, WIDE_MAX);
    push_req(vmpg_pkg::ACT_BWD, OPD_MAX, OPD_MIN, WIDE_MIN);
    push_req(vmpg_pkg::ACT_READ, '0, '0, '0);
    push_req(vmpg_pkg::ACT_READ, OPD_MAX, OPD_MAX, WIDE_MAX);
    // accumulator carries across a backward at the row end
    push_req(vmpg_pkg::ACT_FWD, 16'sd1, '0, '0);
    push_req(vmpg_pkg::ACT_BWD, 16'sd3, 16'sd5, 40'sd7);
    push_req(vmpg_pkg::ACT_FWD, '0, '0, '0);
    push_req(vmpg_pkg::ACT_FWD, 16'sd100, '0, '0);
    // half a row left in the accumulator; the length write must clear it
    push_req(vmpg_pkg::ACT_FWD, 16'sd5, '0, '0);
    drain_block();
    write_length(9'd0);
    push_req(vmpg_pkg::ACT_FWD, 16'sd7, '0, '0);
    push_req(vmpg_pkg::ACT_LOAD, 16'sd1234, '0, '0);
    push_req(vmpg_pkg::ACT_BWD, OPD_MAX, OPD_MAX, WIDE_MIN);
    push_req(vmpg_pkg::ACT_READ, '0, '0, '0);
    push_req(vmpg_pkg::ACT_FWD, '0, '0, '0);
    drain_block();

    // over-range length acts as full size; drive the accumulator into saturation
    tx_pace = pace_t'($urandom_range(0, 2));
    rx_pace = pace_t'($urandom_range(0, 2));
    write_length(9'd511);
    repeat (gen_len) push_req(vmpg_pkg::ACT_LOAD, OPD_MIN, rand_opd(), rand_wide());
    for (r = 0; r < 3; r++) begin
      for (i = 0; i < gen_len; i++) begin
        push_req((r < 2 && i == gen_len - 1) ? vmpg_pkg::ACT_BWD : vmpg_pkg::ACT_FWD,
                 OPD_MIN, rand_opd(), rand_wide());
      end
    end
    repeat (gen_len) push_req(vmpg_pkg::ACT_READ, rand_opd(), rand_opd(), rand_wide());
    drain_block();

    phase = 0;
    while (queued_items < ITEM_TARGET) begin
      case (phase)
        0:       new_len = 9'd256;
        1:       new_len = 9'd1;
        2:       new_len = 9'd300;
        3:       new_len = 9'd32;
        default: new_len = ($urandom_range(0, 9) == 0) ?
                           vmpg_pkg::LEN_W'($urandom_range(17, 64)) :
                           vmpg_pkg::LEN_W'($urandom_range(1, 16));
      endcase
      tx_pace = pace_t'($urandom_range(0, 2));
      rx_pace = pace_t'($urandom_range(0, 2));
      write_length(new_len);
      if (phase == 3) begin
        // receiver holds off while the sender keeps going: the block backs up
        tx_pace = PACE_FULL;
        hold_req = 1'b1;
      end
      if (gen_len > 64) begin
        queue_noise(60);
      end else begin
        queue_layer_pass($urandom_range(1, (gen_len > 16) ? 1 : 3));
        queue_noise(gen_len * $urandom_range(0, 2) + $urandom_range(0, 4));
      end
      if (phase == 4) begin
        drain_block();
        queue_layer_pass(1);
      end
      drain_block();
      phase++;
    end

    drain_block();
    if (errors == 0) begin
      $display("vector_matrix_product_grad_unit_tb: done, clean");
    end else begin
      $display("vector_matrix_product_grad_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* vector_matrix_product_grad_unit.f */
sv/vmpg_pkg.sv
sv/vmpg_front.sv
sv/vmpg_queue.sv
sv/vmpg_back.sv
sv/vector_matrix_product_grad_unit.sv
bench/vector_matrix_product_grad_unit_tb.sv
